// ===== hdl/dls_pkg.sv =====
// ---------------------------------------------------------------------------
// dls_pkg
// shared types and constants for the list scheduler
// ---------------------------------------------------------------------------
package dls_pkg;
  localparam int MaxNodes = 32;
  localparam int NumVars  = 256;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int CountW   = NodeW + 1;
  localparam int VarW     = $clog2(NumVars);
  localparam int PrioW    = 9;
  localparam logic [PrioW-1:0] PrioMax = '1;

  localparam logic [2:0] KIND_LOAD    = 3'd1;
  localparam logic [2:0] KIND_STORE   = 3'd2;
  localparam logic [2:0] KIND_CALL    = 3'd3;
  localparam logic [2:0] KIND_PARAM   = 3'd4;
  localparam logic [2:0] KIND_BARRIER = 3'd5;

  localparam logic [1:0] REG_LOAD_LATENCY = 2'd0;

  typedef logic [MaxNodes-1:0] mask_t;

  typedef struct packed {
    logic [NodeW-1:0] idx;
    logic             valid;
  } node_ptr_t;

  // per-variable table entry
  typedef struct packed {
    logic             def_valid;
    logic [NodeW-1:0] writer;
    mask_t            readers;
  } var_entry_t;
endpackage

// ===== hdl/dag_list_scheduler.sv =====
// ---------------------------------------------------------------------------
// dag_list_scheduler
// builds a dependency graph for one basic block and emits it in list order
// ---------------------------------------------------------------------------
// Input channel: one instruction per beat (in_valid / in_stall). Output
// channel: one scheduled node per beat (out_valid / out_stall). An APB
// port writes load_latency at address 0.
// Each instruction holds the input through the accept state, a read and a
// write-back on the variable table memory for each of the four operand
// slots, used or not, and a final write of the node row; a barrier skips
// the table.
// A beat with last_in_block starts the scheduling phase: a walk from the
// last node down to the first computes priorities, scanning one
// predecessor-matrix column per node, then each emitted node takes one
// selection scan over the nodes. Emission stalls while out_stall is high;
// no input is taken until the block is out.
// Reset clears all control state; the variable table is invalidated by a
// clearing pass over all NumVars entries after reset and after each block,
// during which no input is accepted.
// ---------------------------------------------------------------------------
module dag_list_scheduler (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             kind,
  input  logic [7:0]             use_a_var,
  input  logic                   use_a_valid,
  input  logic [7:0]             use_b_var,
  input  logic                   use_b_valid,
  input  logic [7:0]             use_c_var,
  input  logic                   use_c_valid,
  input  logic [7:0]             def_var,
  input  logic                   def_valid,
  input  logic                   last_in_block,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [4:0]             slot,
  output logic [8:0]             priority_res,
  output logic                   last,
  output logic                   overflow
);
  import dls_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_VRD   = 10'b0000000100,
    S_VWR   = 10'b0000001000,
    S_NODE  = 10'b0000010000,
    S_PRI   = 10'b0000100000,
    S_PRIW  = 10'b0001000000,
    S_SEL   = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_SDONE = 10'b1000000000
  } state_t;

  state_t state;

  logic [3:0] load_latency;

  // variable table memory with epoch-free clearing pass
  var_entry_t       vmem [NumVars];
  logic             vseen [NumVars];
  logic [VarW-1:0]  vaddr;
  var_entry_t       vrd;
  logic             vrd_seen;
  logic             vwe;
  var_entry_t       vwd;
  logic [VarW-1:0]  clr_cnt;

  // per-node memories
  mask_t            pred [MaxNodes];
  logic             is_load [MaxNodes];
  logic [PrioW-1:0] prio [MaxNodes];

  // captured item
  logic [2:0]       k;
  logic [7:0]       va [4];
  logic [3:0]       vv;
  logic             close;
  logic [1:0]       op;
  logic             keep;

  logic [CountW-1:0] node_count;
  logic [NodeW-1:0]  n;
  mask_t             acc;
  node_ptr_t         l_store, l_call, l_param, l_bar;
  mask_t             pending;
  logic              ovf;

  // priority walk
  logic [NodeW-1:0]  pi;
  logic [CountW-1:0] pj;
  logic [PrioW-1:0]  best;
  mask_t             done;
  logic [CountW-1:0] si;
  logic              have;
  logic [NodeW-1:0]  pick;
  logic [PrioW-1:0]  pick_p;
  logic [CountW-1:0] emitted;

  logic [PrioW:0]    psum;
  logic [NodeW-1:0]  pj_n;
  logic [NodeW-1:0]  si_n;
  var_entry_t        cur;
  logic              is_wr;
  logic [PrioW-1:0]  pj_prio;
  logic              pj_edge;
  logic [NodeW-1:0]  last_node;

  assign pready   = 1'b1;
  assign prdata   = {28'd0, load_latency};
  assign in_stall = (state != S_IDLE);
  assign pj_n     = pj[NodeW-1:0];
  assign si_n     = si[NodeW-1:0];
  assign vaddr    = (state == S_CLEAR) ? clr_cnt : va[op];
  assign cur      = vrd_seen ? vrd : '0;
  assign is_wr    = (op == 2'd3);
  assign last_node = NodeW'(node_count - CountW'(1));

  function automatic logic kind_is_bar(input logic [2:0] kk);
    return kk == KIND_BARRIER;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      load_latency <= 4'd3;
    end else if (psel && penable && pwrite && paddr[2] == REG_LOAD_LATENCY[0]
                 && paddr[1:0] == 2'b00) begin
      load_latency <= pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vaddr]  <= vwd;
    end
    if (state == S_CLEAR) begin
      vseen[vaddr] <= 1'b0;
    end else if (vwe) begin
      vseen[vaddr] <= 1'b1;
    end
    vrd      <= vmem[vaddr];
    vrd_seen <= vseen[vaddr];
  end

  always_comb begin
    vwe = (state == S_VWR) && keep && vv[op];
    vwd = cur;
    if (is_wr) begin
      vwd.def_valid = 1'b1;
      vwd.writer    = n;
      vwd.readers   = '0;
    end else begin
      vwd.readers   = cur.readers | (mask_t'(1) << n);
    end
  end

  assign psum = {1'b0, best} + (is_load[pi] ? {6'd0, load_latency} : 10'd1);
  assign pj_prio = prio[pj_n];
  assign pj_edge = pred[pj_n][pi];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      node_count <= '0;
      l_store    <= '0;
      l_call     <= '0;
      l_param    <= '0;
      l_bar      <= '0;
      pending    <= '0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
      done       <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + VarW'(1);
          if (clr_cnt == VarW'(NumVars - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            k     <= kind;
            va[0] <= use_a_var;
            va[1] <= use_b_var;
            va[2] <= use_c_var;
            va[3] <= def_var;
            vv    <= {def_valid, use_c_valid, use_b_valid, use_a_valid};
            close <= last_in_block;
            op    <= 2'd0;
            n     <= node_count[NodeW-1:0];
            keep  <= (node_count < CountW'(MaxNodes));
            if (node_count >= CountW'(MaxNodes)) begin
              ovf <= 1'b1;
            end
            acc   <= '0;
            state <= S_VRD;
          end
        end
        S_VRD: begin
          if (kind_is_bar(k)) begin
            state <= S_NODE;
          end else begin
            state <= S_VWR;
          end
        end
        S_VWR: begin
          if (keep && vv[op]) begin
            if (is_wr) begin
              acc <= acc | (cur.def_valid ? (mask_t'(1) << cur.writer) : '0)
                     | cur.readers;
            end else if (cur.def_valid && cur.writer != n) begin
              acc <= acc | (mask_t'(1) << cur.writer);
            end
          end
          if (op == 2'd3) begin
            state <= S_NODE;
          end else begin
            op    <= op + 2'd1;
            state <= S_VRD;
          end
        end
        S_NODE: begin
          if (keep) begin
            mask_t m;
            m = acc;
            if (l_bar.valid) m[l_bar.idx] = 1'b1;
            if (kind_is_bar(k)) begin
              m = m | ((mask_t'(1) << n) - mask_t'(1));
              l_bar <= '{idx: n, valid: 1'b1};
            end else begin
              if (k == KIND_CALL || k == KIND_STORE || k == KIND_LOAD) begin
                if (l_call.valid)  m[l_call.idx]  = 1'b1;
                if (l_store.valid) m[l_store.idx] = 1'b1;
              end
              if (k == KIND_CALL || k == KIND_STORE) begin
                m = m | pending;
                pending <= '0;
                if (k == KIND_STORE) l_store <= '{idx: n, valid: 1'b1};
              end
              if (k == KIND_LOAD) pending <= pending | (mask_t'(1) << n);
              if (k == KIND_PARAM) begin
                if (l_param.valid) m[l_param.idx] = 1'b1;
                if (l_call.valid)  m[l_call.idx]  = 1'b1;
                l_param <= '{idx: n, valid: 1'b1};
              end
              if (k == KIND_CALL) begin
                if (l_param.valid) m[l_param.idx] = 1'b1;
                l_call  <= '{idx: n, valid: 1'b1};
                l_param <= '0;
              end
            end
            m[n] = 1'b0;
            pred[n]    <= m;
            is_load[n] <= (k == KIND_LOAD);
            node_count <= node_count + CountW'(1);
          end
          if (close) begin
            if (node_count == '0 && !keep) begin
              state <= S_SDONE;
            end else begin
              pi    <= keep ? n : last_node;
              pj    <= CountW'(keep ? n : last_node) + CountW'(1);
              best  <= '0;
              state <= S_PRI;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_PRI: begin
          if (pj >= node_count) begin
            state <= S_PRIW;
          end else begin
            if (pj_edge && pj_prio > best) best <= pj_prio;
            pj <= pj + CountW'(1);
          end
        end
        S_PRIW: begin
          prio[pi] <= (psum > {1'b0, PrioMax}) ? PrioMax : psum[PrioW-1:0];
          if (pi == '0) begin
            done    <= '0;
            si      <= '0;
            have    <= 1'b0;
            emitted <= '0;
            state   <= S_SEL;
          end else begin
            pi    <= pi - NodeW'(1);
            pj    <= CountW'(pi);
            best  <= '0;
            state <= S_PRI;
          end
        end
        S_SEL: begin
          if (si >= node_count) begin
            if (!have) begin
              state <= S_SDONE;
            end else begin
              done         <= done | (mask_t'(1) << pick);
              slot         <= 5'(pick);
              priority_res <= pick_p;
              last         <= (emitted + CountW'(1) == node_count);
              overflow     <= ovf;
              emitted      <= emitted + CountW'(1);
              out_valid    <= 1'b1;
              state        <= S_OUT;
            end
          end else begin
            if (!done[si_n] && (pred[si_n] & ~done) == '0 &&
                (!have || prio[si_n] > pick_p)) begin
              have   <= 1'b1;
              pick   <= si_n;
              pick_p <= prio[si_n];
            end
            si <= si + CountW'(1);
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            si        <= '0;
            have      <= 1'b0;
            state     <= last ? S_SDONE : S_SEL;
          end
        end
        S_SDONE: begin
          node_count <= '0;
          l_store    <= '0;
          l_call     <= '0;
          l_param    <= '0;
          l_bar      <= '0;
          pending    <= '0;
          ovf        <= 1'b0;
          clr_cnt    <= '0;
          state      <= S_CLEAR;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT)
    else $error("result beat outside output state");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall)
    else $error("input taken while busy");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    node_count <= CountW'(MaxNodes))
    else $error("node count beyond capacity");
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    state == S_SDONE |=> state == S_CLEAR && node_count == '0)
    else $error("block state not cleared");
endmodule
